@@ rtl/core/fim_pkg.sv @@
// ----------------------------------------------------------------------------
// fim_pkg
// Types and constants shared by the frame interval meter modules.
// ----------------------------------------------------------------------------
package fim_pkg;

    localparam int unsigned IntervalWidth = 32;
    localparam int unsigned CountWidth    = 64;
    localparam int unsigned NowWidth      = 63;
    localparam logic [31:0] TpsReset      = 32'd10000000;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_STOP  = 2'd1,
        OP_START = 2'd2,
        OP_RESET = 2'd3
    } fim_op_t;

    typedef struct packed {
        logic [1:0]          op;
        logic [NowWidth-1:0] now;
    } fim_in_t;

    typedef struct packed {
        logic [31:0]        avg_interval;
        logic [31:0]        frame_rate;
        logic [31:0]        frame_number;
        logic signed [63:0] total_ticks;
        logic               is_stopped;
    } fim_out_t;

    typedef struct packed {
        logic rd_en;
        logic commit;
    } win_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ rtl/core/fim_window.sv @@
// ----------------------------------------------------------------------------
// fim_window
// Circular interval store with a running sum of the stored intervals.
// ----------------------------------------------------------------------------
module fim_window
    import fim_pkg::*;
#(
    parameter int unsigned DEPTH = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  win_cmd_t                            cmd,
    input  logic [IntervalWidth-1:0]            wr_data,
    output logic [IntervalWidth+$clog2(DEPTH+1)-1:0] sum,
    output logic [$clog2(DEPTH+1)-1:0]          fill
);

    localparam int unsigned FW = $clog2(DEPTH + 1);
    localparam int unsigned SW = IntervalWidth + FW;
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [IntervalWidth-1:0] mem [DEPTH];
    logic [IntervalWidth-1:0] rd_data_reg;
    logic [PW-1:0]            ptr_reg;
    logic [FW-1:0]            fill_reg;
    logic [SW-1:0]            sum_reg;
    logic [SW-1:0]            sum_next;
    logic                     full;

    // The entry under the pointer is the oldest one once the store is full.
    assign full     = (fill_reg == FW'(DEPTH));
    assign sum_next = sum_reg + SW'(wr_data) - (full ? SW'(rd_data_reg) : SW'(0));

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[ptr_reg];
        end
        if (cmd.commit)
        begin
            mem[ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            sum_reg <= sum_next;
            ptr_reg <= (ptr_reg == PW'(DEPTH - 1)) ? '0 : ptr_reg + PW'(1);
            if (!full)
            begin
                fill_reg <= fill_reg + FW'(1);
            end
        end
    end

    assign sum  = sum_reg;
    assign fill = fill_reg;

endmodule

@@ rtl/core/fim_divider.sv @@
// ----------------------------------------------------------------------------
// fim_divider
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fim_divider
    import fim_pkg::*;
#(
    parameter int unsigned DW = 39,
    parameter int unsigned VW = 7
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output div_stat_t     stat,
    output logic [DW-1:0] quotient
);

    localparam int unsigned CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] div_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? VW'(trial - {1'b0, div_reg}) : VW'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CW'(DW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

@@ rtl/core/frame_interval_meter_core.sv @@
// ----------------------------------------------------------------------------
// frame_interval_meter_core
// Pausable frame timer with a moving average of frame intervals.
// ----------------------------------------------------------------------------
//  Channel  Signals                  Handshake
//  in       in_valid/in_ready        in_item (fim_in_t), taken on valid & ready
//  out      out_valid/out_ready      out_item (fim_out_t), taken on valid & ready
//  cfg      cfg_we/cfg_data          ticks_per_second, written when cfg_we
//
//  A running tick passes through the window update and the serial divider
//  that forms the window average. Other operations, and ticks while
//  stopped, skip both; a running tick that leaves the window empty skips
//  the divider.
//  One item is worked on at a time; a finished result waits in the output
//  register while the next item is accepted.
//  Reset needs no clearing pass; window entries are used only once written.
// ----------------------------------------------------------------------------
module frame_interval_meter_core
    import fim_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  fim_in_t     in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output fim_out_t    out_item,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data
);

    localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned SW = IntervalWidth + FW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DEV,
        S_RMW,
        S_DSTART,
        S_DIVW,
        S_FIN,
        S_OUT
    } state_t;

    state_t                   state_reg;
    fim_op_t                  op_reg;
    logic [CountWidth-1:0]    now_reg;
    logic [31:0]              tps_reg;
    logic [CountWidth-1:0]    base_reg;
    logic [CountWidth-1:0]    last_reg;
    logic [CountWidth-1:0]    current_reg;
    logic [CountWidth-1:0]    paused_reg;
    logic [CountWidth-1:0]    stop_reg;
    logic                     stopped_reg;
    logic [31:0]              avg_reg;
    logic [31:0]              frames_sec_reg;
    logic [CountWidth-1:0]    acc_reg;
    logic [31:0]              rate_reg;
    logic [31:0]              frame_cnt_reg;
    logic [31:0]              iv_reg;
    logic                     ins_reg;
    logic [CountWidth-1:0]    part_reg;
    logic                     out_valid_reg;
    fim_out_t                 out_item_reg;

    logic [CountWidth-1:0]    diff;
    logic [31:0]              iv_sat;
    logic [31:0]              dev;
    win_cmd_t                 win_cmd;
    logic [SW-1:0]            win_sum;
    logic [FW-1:0]            win_fill;
    logic                     div_start;
    div_stat_t                div_stat;
    logic [SW-1:0]            div_quo;

    assign diff   = now_reg - last_reg;
    assign iv_sat = (now_reg < last_reg) ? 32'd0 :
                    (diff[63:32] != 32'd0) ? 32'hFFFF_FFFF : diff[31:0];
    assign dev    = (iv_reg >= avg_reg) ? (iv_reg - avg_reg) : (avg_reg - iv_reg);

    assign win_cmd.rd_en  = (state_reg == S_DEV);
    assign win_cmd.commit = (state_reg == S_RMW) && ins_reg;
    assign div_start      = (state_reg == S_DSTART) && (win_fill != FW'(0));

    fim_window #(
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (win_cmd),
        .wr_data (iv_reg),
        .sum     (win_sum),
        .fill    (win_fill)
    );

    fim_divider #(
        .DW (SW),
        .VW (FW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (win_sum),
        .divisor  (win_fill),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_TICK;
            now_reg        <= '0;
            tps_reg        <= TpsReset;
            base_reg       <= '0;
            last_reg       <= '0;
            current_reg    <= '0;
            paused_reg     <= '0;
            stop_reg       <= '0;
            stopped_reg    <= 1'b0;
            avg_reg        <= '0;
            frames_sec_reg <= '0;
            acc_reg        <= '0;
            rate_reg       <= '0;
            frame_cnt_reg  <= '0;
            iv_reg         <= '0;
            ins_reg        <= 1'b0;
            part_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_item_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                tps_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= fim_op_t'(in_item.op);
                        now_reg   <= {1'b0, in_item.now};
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= ((op_reg == OP_TICK) && !stopped_reg) ? S_DEV : S_FIN;
                    case (op_reg)
                        OP_TICK:
                        begin
                            if (stopped_reg)
                            begin
                                avg_reg <= '0;
                            end
                            else
                            begin
                                current_reg <= now_reg;
                                last_reg    <= now_reg;
                                iv_reg      <= iv_sat;
                            end
                        end
                        OP_STOP:
                        begin
                            if (!stopped_reg)
                            begin
                                stop_reg    <= now_reg;
                                stopped_reg <= 1'b1;
                            end
                        end
                        OP_START:
                        begin
                            if (stopped_reg)
                            begin
                                paused_reg  <= paused_reg + (now_reg - stop_reg);
                                last_reg    <= now_reg;
                                stop_reg    <= '0;
                                stopped_reg <= 1'b0;
                            end
                        end
                        default:
                        begin
                            base_reg    <= now_reg;
                            last_reg    <= now_reg;
                            stop_reg    <= '0;
                            stopped_reg <= 1'b0;
                        end
                    endcase
                end
                S_DEV:
                begin
                    ins_reg        <= (dev < tps_reg);
                    frames_sec_reg <= frames_sec_reg + 32'd1;
                    frame_cnt_reg  <= frame_cnt_reg + 32'd1;
                    acc_reg        <= acc_reg + CountWidth'(iv_reg);
                    state_reg      <= S_RMW;
                end
                S_RMW:
                begin
                    if (acc_reg > CountWidth'(tps_reg))
                    begin
                        rate_reg       <= frames_sec_reg;
                        frames_sec_reg <= '0;
                        acc_reg        <= '0;
                    end
                    state_reg <= S_DSTART;
                end
                S_DSTART:
                begin
                    if (win_fill == FW'(0))
                    begin
                        avg_reg   <= '0;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_DIVW;
                    end
                end
                S_DIVW:
                begin
                    if (div_stat.done)
                    begin
                        avg_reg   <= div_quo[31:0];
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    part_reg  <= (stopped_reg ? stop_reg : current_reg) - paused_reg;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_item_reg.avg_interval <= stopped_reg ? 32'd0 : avg_reg;
                        out_item_reg.frame_rate   <= rate_reg;
                        out_item_reg.frame_number <= frame_cnt_reg;
                        out_item_reg.total_ticks  <= $signed(part_reg - base_reg);
                        out_item_reg.is_stopped   <= stopped_reg;
                        out_valid_reg             <= 1'b1;
                        state_reg                 <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ rtl/core/fim_checker.sv @@
// ----------------------------------------------------------------------------
// fim_checker
// Port-level checks on the frame interval meter, bound to the top level.
// ----------------------------------------------------------------------------
module fim_checker
    import fim_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  fim_in_t     in_item,
    input  logic        out_valid,
    input  logic        out_ready,
    input  fim_out_t    out_item
);

    // A held result must not change until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result item changed while stalled");

    // An offered input item stays in place until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_item))
        else $error("input item changed while waiting");

    // A paused timer always reports a zero average.
    a_stopped_avg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_item.is_stopped || out_item.avg_interval == 32'd0))
        else $error("nonzero average while stopped");

    // Only one item is in flight, so ready drops after an accepted item.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input item accepted while another is in progress");

    // A result cannot appear in the cycle right after its item was accepted.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

endmodule

bind frame_interval_meter_core fim_checker u_fim_checker (.*);

@@ tb/sv/frame_interval_meter_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_interval_meter_checker
// Watches the input, output and configuration ports of the frame interval
// meter. It keeps its own copy of the timer state, works out the result
// of every accepted item and compares each result, field by field, with
// the oldest result still owed.
// ----------------------------------------------------------------------------
module frame_interval_meter_checker
    import fim_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  fim_in_t     in_item,
    input  logic        out_valid,
    input  logic        out_ready,
    input  fim_out_t    out_item,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    output int unsigned failures,
    output int unsigned backlog
);

    logic [31:0] rate_cfg;
    logic [63:0] origin_stamp;
    logic [63:0] prev_stamp;
    logic [63:0] latest_stamp;
    logic [63:0] pause_total;
    logic [63:0] halt_stamp;
    logic        halted;
    logic [31:0] recent [WINDOW_DEPTH];
    int unsigned recent_fill;
    logic [31:0] mean_now;
    logic [31:0] frames_open;
    logic [63:0] span_acc;
    logic [31:0] rate_held;
    logic [31:0] frame_total;
    int unsigned fail_tally;
    fim_out_t    owed_results [$];

    function automatic fim_out_t step_meter(input fim_in_t item);
        logic [63:0] stamp;
        logic [63:0] gap;
        logic [63:0] sum;
        logic [31:0] span;
        logic [31:0] dev;
        fim_out_t    res;
        stamp = {1'b0, item.now};
        case (item.op)
            OP_TICK:
            begin
                if (halted)
                begin
                    mean_now = '0;
                end
                else
                begin
                    latest_stamp = stamp;
                    gap = (stamp >= prev_stamp) ? stamp - prev_stamp : 64'd0;
                    span = (gap > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : gap[31:0];
                    prev_stamp = stamp;
                    dev = (span >= mean_now) ? span - mean_now : mean_now - span;
                    if (dev < rate_cfg)
                    begin
                        for (int i = WINDOW_DEPTH - 1; i > 0; i--)
                        begin
                            recent[i] = recent[i - 1];
                        end
                        recent[0] = span;
                        if (recent_fill < WINDOW_DEPTH)
                        begin
                            recent_fill++;
                        end
                    end
                    frames_open++;
                    frame_total++;
                    span_acc += {32'd0, span};
                    if (span_acc > {32'd0, rate_cfg})
                    begin
                        rate_held = frames_open;
                        frames_open = '0;
                        span_acc = '0;
                    end
                    sum = '0;
                    for (int i = 0; i < recent_fill; i++)
                    begin
                        sum += {32'd0, recent[i]};
                    end
                    mean_now = (recent_fill > 0) ? 32'(sum / recent_fill) : 32'd0;
                end
            end
            OP_STOP:
            begin
                if (!halted)
                begin
                    halt_stamp = stamp;
                    halted = 1'b1;
                end
            end
            OP_START:
            begin
                if (halted)
                begin
                    pause_total += stamp - halt_stamp;
                    prev_stamp = stamp;
                    halt_stamp = '0;
                    halted = 1'b0;
                end
            end
            default:
            begin
                origin_stamp = stamp;
                prev_stamp = stamp;
                halt_stamp = '0;
                halted = 1'b0;
            end
        endcase
        res.avg_interval = halted ? 32'd0 : mean_now;
        res.frame_rate   = rate_held;
        res.frame_number = frame_total;
        res.total_ticks  = halted ? halt_stamp - pause_total - origin_stamp
                                  : latest_stamp - pause_total - origin_stamp;
        res.is_stopped   = halted;
        return res;
    endfunction

    task automatic compare_field(input string label, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", label, want, got);
            fail_tally++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        fim_out_t want;
        if (!rst_n)
        begin
            rate_cfg     = TpsReset;
            origin_stamp = '0;
            prev_stamp   = '0;
            latest_stamp = '0;
            pause_total  = '0;
            halt_stamp   = '0;
            halted       = 1'b0;
            recent_fill  = 0;
            mean_now     = '0;
            frames_open  = '0;
            span_acc     = '0;
            rate_held    = '0;
            frame_total  = '0;
            fail_tally   = 0;
            owed_results.delete();
            failures <= 0;
            backlog  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result item arrived with no result owed");
                    fail_tally++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    compare_field("avg_interval", 64'(want.avg_interval),
                                  64'(out_item.avg_interval));
                    compare_field("frame_rate", 64'(want.frame_rate),
                                  64'(out_item.frame_rate));
                    compare_field("frame_number", 64'(want.frame_number),
                                  64'(out_item.frame_number));
                    compare_field("total_ticks", want.total_ticks, out_item.total_ticks);
                    compare_field("is_stopped", 64'(want.is_stopped),
                                  64'(out_item.is_stopped));
                end
            end
            if (cfg_we)
            begin
                rate_cfg = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                owed_results.push_back(step_meter(in_item));
            end
            failures <= fail_tally;
            backlog  <= owed_results.size();
        end
    end

endmodule

@@ tb/sv/frame_interval_meter_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_interval_meter_core_tb
// Drives the frame interval meter with a short directed sequence and then
// with runs of random frame timing under several counter frequencies,
// with random gaps on both channels. A checker alongside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module frame_interval_meter_core_tb;
    import fim_pkg::*;

    localparam int unsigned WINDOW_DEPTH = 64;
    localparam int unsigned StallLimit   = 5000;
    localparam int unsigned PhaseItems   = 275;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    fim_in_t     in_item;
    logic        out_valid;
    logic        out_ready;
    fim_out_t    out_item;
    logic        cfg_we;
    logic [31:0] cfg_data;
    int unsigned failures;
    int unsigned backlog;

    logic [62:0] cursor;
    bit          paused;
    int unsigned send_calm;
    int unsigned quiet_cycles = 0;

    frame_interval_meter_core #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    frame_interval_meter_checker #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .backlog   (backlog)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= StallLimit)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : sink
        int unsigned hold;
        int unsigned calm;
        int unsigned roll;
        hold = 0;
        calm = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (calm > 0)
            begin
                calm--;
                out_ready <= 1'b1;
            end
            else if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                begin
                    calm = $urandom_range(100, 600);
                    out_ready <= 1'b1;
                end
                else if (roll < 60)
                begin
                    out_ready <= 1'b1;
                end
                else if (roll < 92)
                begin
                    hold = $urandom_range(0, 3);
                    out_ready <= 1'b0;
                end
                else
                begin
                    hold = $urandom_range(10, 60);
                    out_ready <= 1'b0;
                end
            end
        end
    end

    task automatic push_item(input fim_op_t op, input logic [62:0] stamp);
        int unsigned roll;
        int unsigned gap;
        gap = 0;
        if (send_calm > 0)
        begin
            send_calm--;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
            begin
                send_calm = $urandom_range(20, 80);
            end
            else if (roll < 60)
            begin
                gap = 0;
            end
            else if (roll < 92)
            begin
                gap = $urandom_range(1, 3);
            end
            else
            begin
                gap = $urandom_range(10, 60);
            end
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{op: op, now: stamp};
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_rate(input logic [31:0] rate);
        cfg_data <= rate;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] rate, input logic [62:0] origin);
        logic [31:0] frame_len;
        logic [31:0] jit;
        logic [63:0] delta;
        logic [62:0] stamp;
        fim_op_t     op;
        int unsigned roll;
        set_rate(rate);
        cursor = origin;
        frame_len = (rate >= 64) ? rate / $urandom_range(8, 120) : $urandom_range(0, 4);
        jit = frame_len / 8;
        repeat (PhaseItems)
        begin
            roll = $urandom_range(0, 99);
            delta = '0;
            if (roll >= 95)
            begin
                op = fim_op_t'($urandom_range(0, 3));
                stamp = 63'({$urandom, $urandom});
            end
            else
            begin
                if (paused ? roll < 60 : roll < 5)
                begin
                    op = paused ? OP_START : OP_STOP;
                    delta = 64'(frame_len) * 64'($urandom_range(0, 20));
                end
                else if (roll < 9)
                begin
                    op = OP_RESET;
                    delta = 64'($urandom_range(0, 1000));
                end
                else
                begin
                    op = OP_TICK;
                    if (roll < 13)
                    begin
                        delta = 64'(rate) + 64'(frame_len) * 64'd2
                              + 64'($urandom_range(0, 100));
                    end
                    else if (roll < 15)
                    begin
                        delta = {$urandom_range(1, 255), $urandom};
                    end
                    else if ($urandom_range(0, 1) == 1)
                    begin
                        delta = 64'(frame_len) + 64'($urandom_range(0, jit));
                    end
                    else
                    begin
                        delta = 64'(frame_len) - 64'($urandom_range(0, jit));
                    end
                end
                if (op == OP_TICK && roll < 17 && roll >= 15)
                begin
                    stamp = cursor - 63'($urandom_range(1, 5000));
                end
                else
                begin
                    stamp = cursor + delta[62:0];
                end
                cursor = stamp;
            end
            case (op)
                OP_STOP:  paused = 1'b1;
                OP_START: paused = 1'b0;
                OP_RESET: paused = 1'b0;
                default:  paused = paused;
            endcase
            push_item(op, stamp);
        end
        drain();
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_item      <= '0;
        cfg_we       <= 1'b0;
        cfg_data     <= '0;
        paused = 1'b0;
        send_calm = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_item(OP_TICK, 63'd0);
        push_item(OP_TICK, 63'd166667);
        push_item(OP_TICK, 63'd333333);
        push_item(OP_TICK, 63'd500000);
        push_item(OP_TICK, 63'd20500000);
        push_item(OP_STOP, 63'd21000000);
        push_item(OP_STOP, 63'd22000000);
        push_item(OP_TICK, 63'd23000000);
        push_item(OP_START, 63'd30000000);
        push_item(OP_START, 63'd31000000);
        push_item(OP_TICK, 63'd29000000);
        push_item(OP_TICK, 63'd29000000 + (63'd1 << 40));
        push_item(OP_RESET, 63'h7FFF_FFFF_FFFF_FFFF);
        push_item(OP_TICK, 63'h7FFF_FFFF_FFFF_FFFF);
        push_item(OP_TICK, 63'd0);
        push_item(OP_RESET, 63'd0);
        push_item(OP_STOP, 63'h7FFF_FFFF_FFFF_FFFF);
        push_item(OP_START, 63'd0);
        push_item(OP_TICK, 63'h2AAA_AAAA_AAAA_AAAA);
        push_item(OP_TICK, 63'h5555_5555_5555_5555);
        drain();

        run_phase(TpsReset, 63'({$urandom_range(0, 1023), $urandom}));
        run_phase(32'd1, 63'($urandom));
        run_phase(32'hFFFF_FFFF, 63'h7FFF_FFF0_0000_0000);
        run_phase(32'd0, 63'($urandom));
        run_phase($urandom_range(100, 200000), 63'({$urandom_range(0, 1023), $urandom}));
        run_phase(32'd60, 63'($urandom));
        run_phase($urandom, 63'({$urandom_range(0, 1023), $urandom}));

        repeat (60) @(posedge clk);
        if (failures == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/fim_pkg.sv
rtl/core/fim_window.sv
rtl/core/fim_divider.sv
rtl/core/frame_interval_meter_core.sv
rtl/core/fim_checker.sv
tb/sv/frame_interval_meter_checker.sv
tb/sv/frame_interval_meter_core_tb.sv
